>>> design/bia_pkg.sv
// Shared constants, types and helper functions of the ID allocator.
`timescale 1ns / 1ps
`default_nettype none

package bia_pkg;

  localparam int unsigned MaxIds       = 1024;
  localparam int unsigned SegmentBits  = 64;
  localparam int unsigned SegmentCount = 16;
  localparam int unsigned FlagBits     = 32;

  localparam int unsigned IdW     = $clog2(MaxIds);
  localparam int unsigned SegIdxW = $clog2(SegmentCount);
  localparam int unsigned BitIdxW = $clog2(SegmentBits);
  localparam int unsigned CntW    = $clog2(MaxIds + 1);
  localparam int unsigned CmdW    = 3;
  localparam int unsigned OutFlgW = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_CREATE = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_EXISTS = 3'd2,
    CMD_GET    = 3'd3,
    CMD_HAS    = 3'd4,
    CMD_NOP    = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // Classified command word handed from the front to the back.
  typedef struct packed {
    cmd_e                cmd;
    logic [IdW-1:0]      id;
    logic [FlagBits-1:0] flags;
  } op_t;

  // Result word.
  typedef struct packed {
    logic [IdW-1:0]     id;
    logic [OutFlgW-1:0] flags;
    logic               answer;
    status_e            status;
    logic [CntW-1:0]    count;
  } res_t;

  // Index of the lowest clear bit of a segment word.
  function automatic logic [BitIdxW-1:0] lowest_zero(input logic [SegmentBits-1:0] w);
    logic [BitIdxW-1:0] idx;
    idx = '0;
    for (int i = SegmentBits - 1; i >= 0; i--) begin
      if (!w[i]) idx = BitIdxW'(i);
    end
    return idx;
  endfunction

  // First segment at or after start (wrapping) whose full bit is clear.
  function automatic logic [SegIdxW-1:0] first_open_seg(input logic [SegmentCount-1:0] full,
                                                       input logic [SegIdxW-1:0] start);
    logic [2*SegmentCount-1:0] dbl;
    logic [SegIdxW-1:0]        off;
    dbl = {~full, ~full} >> start;
    off = '0;
    for (int i = SegmentCount - 1; i >= 0; i--) begin
      if (dbl[i]) off = SegIdxW'(i);
    end
    return start + off;
  endfunction

endpackage

`default_nettype wire

>>> design/bitmap_id_allocator_with_flags_unit.sv
// Top level of the bitmap ID allocator with a flag word per ID.
`timescale 1ns / 1ps
`default_nettype none

// ID allocator over 1024 IDs kept as sixteen 64-bit occupancy segments, with
// a 32-bit flag word stored per ID. Both sides look like queues: a command
// word (command, entity_id, flag_word) is taken when push is high and full is
// low; a result word sits on the result ports while empty is low and leaves
// when pop is high. Commands: 0 create, 1 remove, 2 exists, 3 get flags,
// 4 has-all-components; codes 5..7 do nothing and answer status ok. Create
// tries the next-fit candidate ID; if it is taken, it jumps to the first
// segment at or after the candidate's that is not full (wrapping) and takes
// its lowest free bit. A full table gives status 2 and ID 0. Absent IDs give
// status 1 with zero flags and answer. live_count is the number of allocated
// IDs after the command. Timing: a two-word command queue feeds a sequencer
// that handles one word at a time, one bitmap segment read per cycle. The
// sequencer takes a word from the command queue in S_IDLE when the result
// queue has room, then looks it up in S_LOOK, where exists, remove, no-op,
// full-table create and create on a free candidate finish; get flags and
// has-components go on to S_FLAG (one flag RAM read); create that has to
// scan passes S_SCAN and picks its bit in S_PICK from the segment found in
// S_LOOK. A word waits in the command queue until the sequencer is idle, and
// its result word can be popped in the cycle after it enters the two-word
// result queue. The bitmap resets to empty at once; no clearing pass is
// needed, and the flag RAM is only read for allocated IDs.
module bitmap_id_allocator_with_flags_unit import bia_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [CmdW-1:0]     command_i,
  input  wire logic [IdW-1:0]      entity_id_i,
  input  wire logic [FlagBits-1:0] flag_word_i,
  output logic                     empty,
  input  wire logic                pop,
  output logic [IdW-1:0]           result_id_o,
  output logic [OutFlgW-1:0]       result_flags_o,
  output logic                     answer_o,
  output logic [1:0]               status_o,
  output logic [CntW-1:0]          live_count_o
);

  op_t  op;
  logic op_empty, op_pop;
  res_t res_in, res_out;
  logic res_full, res_push;

  // Front: decode and buffer incoming command words.
  bia_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .command_i   (command_i),
    .entity_id_i (entity_id_i),
    .flag_word_i (flag_word_i),
    .pop_i       (op_pop),
    .empty_o     (op_empty),
    .op_o        (op)
  );

  // Back: executes one command word at a time against the bitmap.
  bia_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_empty_i (op_empty),
    .op_i       (op),
    .op_pop_o   (op_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // Result words wait here so the back keeps going while the sink stalls, until the queue is full.
  bia_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .res_o   (res_out)
  );

  assign result_id_o    = res_out.id;
  assign result_flags_o = res_out.flags;
  assign answer_o       = res_out.answer;
  assign status_o       = res_out.status;
  assign live_count_o   = res_out.count;

endmodule

`default_nettype wire

>>> design/bia_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bia_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> design/bia_front.sv
// Front end: command decode and two-word command queue.
`timescale 1ns / 1ps
`default_nettype none

module bia_front import bia_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  output logic                     full_o,
  input  wire logic [CmdW-1:0]     command_i,
  input  wire logic [IdW-1:0]      entity_id_i,
  input  wire logic [FlagBits-1:0] flag_word_i,
  input  wire logic                pop_i,
  output logic                     empty_o,
  output op_t                      op_o
);

  op_t        entry_q [2];
  op_t        dec;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  // Codes 5..7 mean nothing; they become a no-op.
  always_comb begin
    dec.id    = entity_id_i;
    dec.flags = flag_word_i;
    unique case (command_i) inside
      CMD_CREATE, CMD_REMOVE, CMD_EXISTS, CMD_GET, CMD_HAS: dec.cmd = cmd_e'(command_i);
      default:                                             dec.cmd = CMD_NOP;
    endcase
  end

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign op_o    = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

>>> design/bia_resq.sv
// Two-word result queue in front of the output ports.
`timescale 1ns / 1ps
`default_nettype none

module bia_resq import bia_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  res_t      res_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output res_t      res_o
);

  res_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign res_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= res_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

>>> design/bia_back.sv
// Back end: bitmap, counters, flag RAM and the command sequencer.
`timescale 1ns / 1ps
`default_nettype none

module bia_back import bia_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic op_empty_i,
  input  op_t       op_i,
  output logic      op_pop_o,
  input  wire logic res_full_i,
  output logic      res_push_o,
  output res_t      res_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_SCAN = 5'b00100,
    S_PICK = 5'b01000,
    S_FLAG = 5'b10000
  } state_e;

  state_e                    state_q, state_d;
  op_t                       op_q, op_d;
  logic [SegmentBits-1:0]    bitmap_q [SegmentCount];
  logic [SegmentCount-1:0]   full_q;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [IdW-1:0]            cand_q, cand_d;
  logic [SegIdxW-1:0]        scan_seg_q, scan_seg_d;

  logic [IdW-1:0]            look_id, new_id;
  logic [SegIdxW-1:0]        bm_raddr, bm_waddr;
  logic [SegmentBits-1:0]    seg_word, bm_wdata;
  logic                      bm_we, hit, commit;
  logic                      flag_we, flag_re;
  logic [IdW-1:0]            flag_waddr;
  logic [FlagBits-1:0]       flag_wdata, flag_rdata;
  logic                      tbl_full;

  assign look_id  = (op_q.cmd == CMD_CREATE) ? cand_q : op_q.id;
  assign bm_raddr = (state_q == S_PICK) ? scan_seg_q : look_id[IdW-1:BitIdxW];
  assign seg_word = bitmap_q[bm_raddr];
  assign hit      = seg_word[look_id[BitIdxW-1:0]];
  assign tbl_full = (cnt_q == CntW'(MaxIds));

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cnt_d      = cnt_q;
    cand_d     = cand_q;
    scan_seg_d = scan_seg_q;
    op_pop_o   = 1'b0;
    res_push_o = 1'b0;
    bm_we      = 1'b0;
    bm_waddr   = bm_raddr;
    bm_wdata   = seg_word;
    flag_we    = 1'b0;
    flag_waddr = op_q.id;
    flag_wdata = '0;
    flag_re    = 1'b0;
    commit     = 1'b0;
    new_id     = cand_q;

    res_o.id     = op_q.id;
    res_o.flags  = '0;
    res_o.answer = 1'b0;
    res_o.status = ST_OK;
    res_o.count  = cnt_q;

    unique case (state_q)
      S_IDLE: begin
        // Result space is checked here; nothing else fills the queue.
        if (!op_empty_i && !res_full_i) begin
          op_pop_o = 1'b1;
          op_d     = op_i;
          state_d  = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_IDLE;
        unique case (op_q.cmd) inside
          CMD_CREATE: begin
            if (tbl_full) begin
              res_o.id     = '0;
              res_o.status = ST_FULL;
              res_push_o   = 1'b1;
            end else if (!hit) begin
              new_id = cand_q;
              commit = 1'b1;
            end else begin
              scan_seg_d = first_open_seg(full_q, cand_q[IdW-1:BitIdxW]);
              state_d    = S_SCAN;
            end
          end
          CMD_REMOVE: begin
            if (!hit) begin
              res_o.status = ST_ABSENT;
            end else begin
              bm_we       = 1'b1;
              bm_wdata    = seg_word & ~(SegmentBits'(1) << op_q.id[BitIdxW-1:0]);
              flag_we     = 1'b1;
              cnt_d       = cnt_q - CntW'(1);
              res_o.count = cnt_d;
            end
            res_push_o = 1'b1;
          end
          CMD_EXISTS: begin
            res_o.answer = hit;
            res_o.status = hit ? ST_OK : ST_ABSENT;
            res_push_o   = 1'b1;
          end
          CMD_GET, CMD_HAS: begin
            if (!hit) begin
              res_o.status = ST_ABSENT;
              res_push_o   = 1'b1;
            end else begin
              flag_re = 1'b1;
              state_d = S_FLAG;
            end
          end
          default: begin
            res_push_o = 1'b1;
          end
        endcase
      end
      S_SCAN: begin
        state_d = S_PICK;
      end
      S_PICK: begin
        new_id  = {scan_seg_q, lowest_zero(seg_word)};
        commit  = 1'b1;
        state_d = S_IDLE;
      end
      S_FLAG: begin
        if (op_q.cmd == CMD_GET) begin
          res_o.flags = OutFlgW'(flag_rdata);
        end else begin
          res_o.answer = ((flag_rdata & op_q.flags) == op_q.flags);
        end
        res_push_o = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Allocation of new_id, shared by the fast path and the scan path.
    if (commit) begin
      bm_we       = 1'b1;
      bm_waddr    = new_id[IdW-1:BitIdxW];
      bm_wdata    = seg_word | (SegmentBits'(1) << new_id[BitIdxW-1:0]);
      flag_we     = 1'b1;
      flag_waddr  = new_id;
      flag_wdata  = op_q.flags;
      cnt_d       = cnt_q + CntW'(1);
      cand_d      = (new_id == IdW'(MaxIds - 1)) ? '0 : new_id + IdW'(1);
      res_o.id    = new_id;
      res_o.count = cnt_d;
      res_push_o  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      cand_q     <= '0;
      scan_seg_q <= '0;
      full_q     <= '0;
      for (int i = 0; i < SegmentCount; i++) bitmap_q[i] <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      cand_q     <= cand_d;
      scan_seg_q <= scan_seg_d;
      if (bm_we) begin
        bitmap_q[bm_waddr] <= bm_wdata;
        full_q[bm_waddr]   <= &bm_wdata;
      end
    end
  end

  bia_ram #(
    .Width (FlagBits),
    .Depth (MaxIds)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (flag_waddr),
    .wdata_i (flag_wdata),
    .re_i    (flag_re),
    .raddr_i (op_q.id),
    .rdata_o (flag_rdata)
  );

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxIds))
    else $error("live count above table size");

  a_pick_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PICK) |-> !full_q[scan_seg_q])
    else $error("scan chose a full segment");

  a_scan_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !tbl_full)
    else $error("scan started on a full table");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_push_o |=> $stable(cnt_q))
    else $error("count moved without a result");

endmodule

`default_nettype wire
